FILE: src/bocc_pkg.sv
package bocc_pkg;

  localparam int COORD_BITS      = 16;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int MARGIN_W        = 14;
  localparam int COUNT_W         = 5;
  localparam int SLOT_W          = 4;
  localparam int CAUSE_W         = 2;
  localparam int NUM_CORNERS     = 4;
  localparam int NUM_EDGES       = 4;
  localparam int NUM_AXES        = NUM_EDGES + 2;
  localparam int AXIS_X          = NUM_EDGES;
  localparam int AXIS_Y          = NUM_EDGES + 1;
  localparam int MAX_OBSTACLES_DEF = 16;

  localparam int GROW_W  = COORD_BITS + 2;
  localparam int AXIS_W  = COORD_BITS + 1;
  localparam int QPROD_W = COORD_BITS + AXIS_W;
  localparam int RPROD_W = GROW_W + AXIS_W;
  localparam int PROJ_W  = RPROD_W + 1;

  localparam int IN_PAYLOAD_W = SLOT_W + 2 * NUM_CORNERS * COORD_BITS;
  localparam int IN_TDATA_W   = ((IN_PAYLOAD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((1 + CAUSE_W + 7) / 8) * 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [GROW_W-1:0]     grow_t;
  typedef logic signed [AXIS_W-1:0]     axis_t;
  typedef logic signed [QPROD_W-1:0]    qprod_t;
  typedef logic signed [RPROD_W-1:0]    rprod_t;
  typedef logic signed [PROJ_W-1:0]     proj_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
  } box_t;

  typedef struct packed {
    coord_t               bmin_x;
    coord_t               bmin_y;
    coord_t               bmax_x;
    coord_t               bmax_y;
    logic [MARGIN_W-1:0]  margin;
    logic [COUNT_W-1:0]   count;
  } cfg_t;

  typedef struct packed {
    axis_t [NUM_EDGES-1:0] ax;
    axis_t [NUM_EDGES-1:0] ay;
    logic  [NUM_EDGES-1:0] nz;
    proj_t [NUM_AXES-1:0]  pmin;
    proj_t [NUM_AXES-1:0]  pmax;
  } quad_proj_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } hit_t;

  localparam logic FUNC_CHECK = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [CAUSE_W-1:0] CAUSE_CLEAR    = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_BOUNDS   = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_OBSTACLE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BOUND_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_MAX_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_MAX_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT       = 3'd5;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

endpackage

FILE: src/bocc_table.sv
module bocc_table
  import bocc_pkg::*;
#(
  parameter int DEPTH = MAX_OBSTACLES_DEF,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  box_t          wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output box_t          rd_data
);

  box_t mem [DEPTH];
  box_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/bocc_quad.sv
module bocc_quad
  import bocc_pkg::*;
(
  input  logic                      clk,
  input  logic                      start,
  input  coord_t [NUM_CORNERS-1:0]  cx,
  input  coord_t [NUM_CORNERS-1:0]  cy,
  input  cfg_t                      cfg,
  output logic                      oob,
  output quad_proj_t                proj
);

  // stage 1: edge normals and bounds test
  coord_t [NUM_CORNERS-1:0] cx_r, cy_r;
  axis_t  [NUM_EDGES-1:0]   ax_r, ay_r, ax_nxt, ay_nxt;
  logic   [NUM_EDGES-1:0]   nz_r, nz_nxt;
  logic                     oob_r, oob_nxt;

  // stage 2..4: corner projections onto the edge normals
  qprod_t mx_r  [NUM_EDGES][NUM_CORNERS];
  qprod_t my_r  [NUM_EDGES][NUM_CORNERS];
  proj_t  dot_r [NUM_EDGES][NUM_CORNERS];
  proj_t  [NUM_AXES-1:0] pmin_r, pmax_r, pmin_nxt, pmax_nxt;

  always_comb begin
    grow_t margin_g;
    grow_t lo_x, lo_y, hi_x, hi_y;
    margin_g = grow_t'(cfg.margin);
    lo_x = grow_t'(cfg.bmin_x) + margin_g;
    lo_y = grow_t'(cfg.bmin_y) + margin_g;
    hi_x = grow_t'(cfg.bmax_x) - margin_g;
    hi_y = grow_t'(cfg.bmax_y) - margin_g;
    oob_nxt = 1'b0;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      if (grow_t'(cx[i]) < lo_x || grow_t'(cx[i]) > hi_x ||
          grow_t'(cy[i]) < lo_y || grow_t'(cy[i]) > hi_y) begin
        oob_nxt = 1'b1;
      end
    end
    for (int e = 0; e < NUM_EDGES; e++) begin
      ax_nxt[e] = axis_t'(cy[e]) - axis_t'(cy[(e + 1) % NUM_CORNERS]);
      ay_nxt[e] = axis_t'(cx[(e + 1) % NUM_CORNERS]) - axis_t'(cx[e]);
      nz_nxt[e] = (ax_nxt[e] != '0) || (ay_nxt[e] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cx_r  <= cx;
      cy_r  <= cy;
      ax_r  <= ax_nxt;
      ay_r  <= ay_nxt;
      nz_r  <= nz_nxt;
      oob_r <= oob_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        mx_r[e][i]  <= qprod_t'(cx_r[i]) * qprod_t'(ax_r[e]);
        my_r[e][i]  <= qprod_t'(cy_r[i]) * qprod_t'(ay_r[e]);
        dot_r[e][i] <= proj_t'(mx_r[e][i]) + proj_t'(my_r[e][i]);
      end
    end
  end

  always_comb begin
    proj_t lo01, lo23, hi01, hi23;
    coord_t xl01, xl23, xh01, xh23, yl01, yl23, yh01, yh23;
    for (int e = 0; e < NUM_EDGES; e++) begin
      lo01 = (dot_r[e][0] < dot_r[e][1]) ? dot_r[e][0] : dot_r[e][1];
      lo23 = (dot_r[e][2] < dot_r[e][3]) ? dot_r[e][2] : dot_r[e][3];
      hi01 = (dot_r[e][0] > dot_r[e][1]) ? dot_r[e][0] : dot_r[e][1];
      hi23 = (dot_r[e][2] > dot_r[e][3]) ? dot_r[e][2] : dot_r[e][3];
      pmin_nxt[e] = (lo01 < lo23) ? lo01 : lo23;
      pmax_nxt[e] = (hi01 > hi23) ? hi01 : hi23;
    end
    xl01 = (cx_r[0] < cx_r[1]) ? cx_r[0] : cx_r[1];
    xl23 = (cx_r[2] < cx_r[3]) ? cx_r[2] : cx_r[3];
    xh01 = (cx_r[0] > cx_r[1]) ? cx_r[0] : cx_r[1];
    xh23 = (cx_r[2] > cx_r[3]) ? cx_r[2] : cx_r[3];
    yl01 = (cy_r[0] < cy_r[1]) ? cy_r[0] : cy_r[1];
    yl23 = (cy_r[2] < cy_r[3]) ? cy_r[2] : cy_r[3];
    yh01 = (cy_r[0] > cy_r[1]) ? cy_r[0] : cy_r[1];
    yh23 = (cy_r[2] > cy_r[3]) ? cy_r[2] : cy_r[3];
    pmin_nxt[AXIS_X] = proj_t'((xl01 < xl23) ? xl01 : xl23);
    pmax_nxt[AXIS_X] = proj_t'((xh01 > xh23) ? xh01 : xh23);
    pmin_nxt[AXIS_Y] = proj_t'((yl01 < yl23) ? yl01 : yl23);
    pmax_nxt[AXIS_Y] = proj_t'((yh01 > yh23) ? yh01 : yh23);
  end

  always_ff @(posedge clk) begin
    pmin_r <= pmin_nxt;
    pmax_r <= pmax_nxt;
  end

  assign oob = oob_r;

  always_comb begin
    proj.ax   = ax_r;
    proj.ay   = ay_r;
    proj.nz   = nz_r;
    proj.pmin = pmin_r;
    proj.pmax = pmax_r;
  end

endmodule

FILE: src/bocc_sat.sv
module bocc_sat
  import bocc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       issue,
  input  logic       flush,
  input  box_t       rd_data,
  input  cfg_t       cfg,
  input  quad_proj_t proj,
  output hit_t       res
);

  localparam int DEPTH = 5;

  logic [DEPTH-1:0] v_r;

  grow_t gx0_r, gx1_r, gy0_r, gy1_r;
  grow_t mgx0_r, mgx1_r, mgy0_r, mgy1_r;
  rprod_t xa0_r [NUM_EDGES];
  rprod_t xa1_r [NUM_EDGES];
  rprod_t yb0_r [NUM_EDGES];
  rprod_t yb1_r [NUM_EDGES];
  proj_t [NUM_AXES-1:0] rmin_r, rmax_r, rmin_nxt, rmax_nxt;
  logic hit_r, hit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[DEPTH-2:0], issue};
    end
  end

  // grow the entry by the margin
  always_ff @(posedge clk) begin
    gx0_r <= grow_t'(rd_data.min_x) - grow_t'(cfg.margin);
    gy0_r <= grow_t'(rd_data.min_y) - grow_t'(cfg.margin);
    gx1_r <= grow_t'(rd_data.max_x) + grow_t'(cfg.margin);
    gy1_r <= grow_t'(rd_data.max_y) + grow_t'(cfg.margin);
  end

  // rectangle projections separate into x and y terms
  always_ff @(posedge clk) begin
    mgx0_r <= gx0_r;
    mgx1_r <= gx1_r;
    mgy0_r <= gy0_r;
    mgy1_r <= gy1_r;
    for (int e = 0; e < NUM_EDGES; e++) begin
      xa0_r[e] <= rprod_t'(gx0_r) * rprod_t'(proj.ax[e]);
      xa1_r[e] <= rprod_t'(gx1_r) * rprod_t'(proj.ax[e]);
      yb0_r[e] <= rprod_t'(gy0_r) * rprod_t'(proj.ay[e]);
      yb1_r[e] <= rprod_t'(gy1_r) * rprod_t'(proj.ay[e]);
    end
  end

  always_comb begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      rmin_nxt[e] = proj_t'((xa0_r[e] < xa1_r[e]) ? xa0_r[e] : xa1_r[e]) +
                    proj_t'((yb0_r[e] < yb1_r[e]) ? yb0_r[e] : yb1_r[e]);
      rmax_nxt[e] = proj_t'((xa0_r[e] > xa1_r[e]) ? xa0_r[e] : xa1_r[e]) +
                    proj_t'((yb0_r[e] > yb1_r[e]) ? yb0_r[e] : yb1_r[e]);
    end
    rmin_nxt[AXIS_X] = proj_t'((mgx0_r < mgx1_r) ? mgx0_r : mgx1_r);
    rmax_nxt[AXIS_X] = proj_t'((mgx0_r > mgx1_r) ? mgx0_r : mgx1_r);
    rmin_nxt[AXIS_Y] = proj_t'((mgy0_r < mgy1_r) ? mgy0_r : mgy1_r);
    rmax_nxt[AXIS_Y] = proj_t'((mgy0_r > mgy1_r) ? mgy0_r : mgy1_r);
  end

  always_ff @(posedge clk) begin
    rmin_r <= rmin_nxt;
    rmax_r <= rmax_nxt;
  end

  // touching counts as overlap; a zero normal never separates
  always_comb begin
    logic [NUM_AXES-1:0] ov;
    for (int a = 0; a < NUM_AXES; a++) begin
      ov[a] = !(proj.pmax[a] < rmin_r[a] || rmax_r[a] < proj.pmin[a]);
    end
    for (int e = 0; e < NUM_EDGES; e++) begin
      ov[e] = ov[e] || !proj.nz[e];
    end
    hit_nxt = &ov;
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
  end

  assign res.valid = v_r[DEPTH-1];
  assign res.hit   = hit_r;

endmodule

FILE: src/box_obstacle_collision_check.sv
// Channel | Dir | Ports                        | Beat contents
// in      | in  | in_tvalid/tready/tdata/tuser | tuser: func; tdata: slot, corner0..3 x/y
// out     | out | out_tvalid/tready/tdata      | tdata: collides, cause
// cfg     | in  | cfg_we/index/wdata           | one register write per cycle
//
// A write beat leaves the block ready. With n = min(obstacle_count, MAX_OBSTACLES), a check
// beat holds the block until all n entries are tested with no hit, or until the first hit
// in entry order from zero; it ends without reading the table when n is zero or a corner
// lies outside the padded bounds. The table has one read port, so one entry enters the
// five-stage test pipeline per cycle.
// Reset is synchronous; the obstacle table is not cleared and needs no sweep.
// A result waits in the output register while the next beat is accepted; a check
// that finishes while it is still held stalls until out_tready.
module box_obstacle_collision_check
  import bocc_pkg::*;
#(
  parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // slot, c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y
  input  logic                   in_tuser,   // func
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // collides, cause
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_HOLD} state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    issue_cnt_r, done_cnt_r, n_eff;
  logic                out_valid_r, out_collides_r;
  logic [CAUSE_W-1:0]  out_cause_r, res_cause_r, dec_cause;
  cfg_t                cfg_r;

  coord_t [NUM_CORNERS-1:0] cx, cy;
  logic [SLOT_W-1:0]   slot;
  logic                in_acc, chk_acc, wr_en, out_free, out_load, decide, issue, oob;
  box_t                wr_box, rd_box;
  quad_proj_t          proj;
  hit_t                hit;

  always_comb begin
    slot = in_tdata[SLOT_W-1:0];
    for (int k = 0; k < NUM_CORNERS; k++) begin
      cx[k] = in_tdata[SLOT_W + 2 * k * COORD_BITS +: COORD_BITS];
      cy[k] = in_tdata[SLOT_W + (2 * k + 1) * COORD_BITS +: COORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bmin_x <= COORD_MIN;
      cfg_r.bmin_y <= COORD_MIN;
      cfg_r.bmax_x <= COORD_MAX;
      cfg_r.bmax_y <= COORD_MAX;
      cfg_r.margin <= '0;
      cfg_r.count  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOUND_MIN_X: cfg_r.bmin_x <= cfg_wdata[COORD_BITS-1:0];
        REG_BOUND_MIN_Y: cfg_r.bmin_y <= cfg_wdata[COORD_BITS-1:0];
        REG_BOUND_MAX_X: cfg_r.bmax_x <= cfg_wdata[COORD_BITS-1:0];
        REG_BOUND_MAX_Y: cfg_r.bmax_y <= cfg_wdata[COORD_BITS-1:0];
        REG_MARGIN:      cfg_r.margin <= cfg_wdata[MARGIN_W-1:0];
        REG_COUNT:       cfg_r.count  <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(cfg_r.count) > MAX_OBSTACLES) begin
      n_eff = CNT_W'(MAX_OBSTACLES);
    end else begin
      n_eff = CNT_W'(cfg_r.count);
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign chk_acc   = in_acc && (in_tuser == FUNC_CHECK);
  assign wr_en     = in_acc && (in_tuser == FUNC_WRITE) && (int'(slot) < MAX_OBSTACLES);
  assign out_free  = !out_valid_r || out_tready;

  assign wr_box.min_x = cx[0];
  assign wr_box.min_y = cy[0];
  assign wr_box.max_x = cx[2];
  assign wr_box.max_y = cy[2];

  always_comb begin
    decide    = 1'b0;
    dec_cause = CAUSE_CLEAR;
    if (state_r == ST_BUSY) begin
      if (oob) begin
        decide    = 1'b1;
        dec_cause = CAUSE_BOUNDS;
      end else if (hit.valid && hit.hit) begin
        decide    = 1'b1;
        dec_cause = CAUSE_OBSTACLE;
      end else if (done_cnt_r == n_eff) begin
        decide    = 1'b1;
        dec_cause = CAUSE_CLEAR;
      end else begin
        decide    = 1'b0;
      end
    end
  end

  assign issue    = (state_r == ST_BUSY) && !decide && (issue_cnt_r < n_eff);
  assign out_load = out_free && (decide || (state_r == ST_HOLD));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_cnt_r <= '0;
      done_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (chk_acc) begin
            state_r     <= ST_BUSY;
            issue_cnt_r <= '0;
            done_cnt_r  <= '0;
          end
        end
        ST_BUSY: begin
          if (issue) begin
            issue_cnt_r <= issue_cnt_r + 1'b1;
          end
          if (hit.valid) begin
            done_cnt_r <= done_cnt_r + 1'b1;
          end
          if (decide) begin
            if (out_free) begin
              out_cause_r    <= dec_cause;
              out_collides_r <= (dec_cause != CAUSE_CLEAR);
              state_r        <= ST_IDLE;
            end else begin
              res_cause_r <= dec_cause;
              state_r     <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_cause_r    <= res_cause_r;
            out_collides_r <= (res_cause_r != CAUSE_CLEAR);
            state_r        <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_cause_r, out_collides_r});

  bocc_table #(
    .DEPTH (MAX_OBSTACLES),
    .AW    (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(slot)),
    .wr_data (wr_box),
    .rd_en   (issue),
    .rd_addr (issue_cnt_r[IDX_W-1:0]),
    .rd_data (rd_box)
  );

  bocc_quad u_quad (
    .clk   (clk),
    .start (chk_acc),
    .cx    (cx),
    .cy    (cy),
    .cfg   (cfg_r),
    .oob   (oob),
    .proj  (proj)
  );

  bocc_sat u_sat (
    .clk     (clk),
    .rst_n   (rst_n),
    .issue   (issue),
    .flush   (decide),
    .rd_data (rd_box),
    .cfg     (cfg_r),
    .proj    (proj),
    .res     (hit)
  );

endmodule

FILE: src/bocc_checker.sv
module bocc_checker
  import bocc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // collides agrees with cause, cause is a known code, padding is zero
  a_out_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[2:1] != CAUSE_CLEAR)) &&
                   (out_tdata[2:1] == CAUSE_CLEAR || out_tdata[2:1] == CAUSE_BOUNDS ||
                    out_tdata[2:1] == CAUSE_OBSTACLE) &&
                   (out_tdata[OUT_TDATA_W-1:3] == '0))
    else $error("malformed result beat");

  // a check keeps the input closed for at least the next cycle
  a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_CHECK) |=> !in_tready)
    else $error("input open straight after a check");

  // a table write leaves the block ready
  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_WRITE) |=> in_tready)
    else $error("input closed after a table write");

endmodule

bind box_obstacle_collision_check bocc_checker u_bocc_checker (.*);
